// File: sv/rc4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RC4 byte cipher.
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;
    localparam int PERM_DEPTH = 256;

    // Item kinds on the input channel
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_J,
        ST_KS_W1,
        ST_KS_W2,
        ST_P_J,
        ST_P_SWAP,
        ST_P_KS
    } state_t;

    // Request to the permutation memory: write port and read address
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] raddr;
    } perm_req_t;

    // Result word handed to the output queue
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } push_t;

endpackage

// File: sv/rc4_ram.sv
`timescale 1ns / 1ps
// Generic one-write, one-read synchronous RAM with registered, write-first read.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read, passing the new word through on an address match
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/rc4_outq.sv
`timescale 1ns / 1ps
// Two-entry result queue in front of the output channel.
module rc4_outq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rc4_pkg::push_t              push,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]  byte_out,
    output logic [1:0]                  level
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              pop;

    assign out_valid = (count_reg != 2'd0);
    assign byte_out  = slot_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign pop       = out_valid && !out_stall;

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/rc4_engine.sv
`timescale 1ns / 1ps
// Sequencer and datapath: key loads, key schedule and keystream steps over the memories.
module rc4_engine #(
    parameter int KEY_DEPTH = 256,
    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [7:0]                  key_index,
    input  logic [rc4_pkg::BYTE_W-1:0]  byte_in,
    input  logic                        last_of_buffer,
    input  logic [rc4_pkg::LEN_W-1:0]   key_length,
    output rc4_pkg::perm_req_t          perm_req,
    input  logic [rc4_pkg::BYTE_W-1:0]  perm_rdata,
    output logic                        key_we,
    output logic [KW-1:0]               key_waddr,
    output logic [rc4_pkg::BYTE_W-1:0]  key_wdata,
    output logic [KW-1:0]               key_raddr,
    input  logic [rc4_pkg::BYTE_W-1:0]  key_rdata,
    input  logic [1:0]                  q_level,
    output rc4_pkg::push_t              push
);
    import rc4_pkg::*;

    state_t            state_reg;
    state_t            state_next;

    logic [BYTE_W-1:0] i_reg;
    logic [BYTE_W-1:0] j_reg;
    logic              sched_reg;

    logic [BYTE_W-1:0] n_reg;
    logic [LEN_W-1:0]  kpos_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [BYTE_W-1:0] si_reg;
    logic              hit_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;

    logic              can_take;
    logic              accept;
    logic              take_data;
    logic              sched_now;
    logic              n_last;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  kpos_inc;
    logic [BYTE_W-1:0] acc_new;
    logic [BYTE_W-1:0] j_new;
    logic [BYTE_W-1:0] ks;

    // Handshake: take a word only where the queue will have room for its result
    assign can_take  = ((state_reg == ST_IDLE) && (q_level <= 2'd1))
                    || ((state_reg == ST_P_KS) && (q_level == 2'd0));
    assign in_stall  = !can_take;
    assign accept    = in_valid && can_take;
    assign take_data = accept && (req_type == REQ_DATA);

    // The flag seen by a word taken while the previous one finishes
    assign sched_now = (state_reg == ST_P_KS) ? last_reg : sched_reg;

    assign n_last   = (n_reg == BYTE_W'(PERM_DEPTH - 1));
    assign kpos_inc = ((kpos_reg + LEN_W'(1)) == len_reg) ? '0 : kpos_reg + LEN_W'(1);
    assign acc_new  = acc_reg + perm_rdata + key_rdata;
    assign j_new    = j_reg + perm_rdata;
    assign ks       = hit_reg ? si_reg : perm_rdata;

    // Clamp key length to the store
    always_comb
    begin
        priority if (key_length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (key_length > LEN_W'(KEY_DEPTH))
        begin
            eff_len = LEN_W'(KEY_DEPTH);
        end
        else
        begin
            eff_len = key_length;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_P_KS:
            begin
                if (take_data)
                begin
                    state_next = sched_now ? ST_FILL : ST_P_J;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:   state_next = n_last ? ST_KS_J : ST_FILL;
            ST_KS_J:   state_next = ST_KS_W1;
            ST_KS_W1:  state_next = ST_KS_W2;
            ST_KS_W2:  state_next = n_last ? ST_P_J : ST_KS_J;
            ST_P_J:    state_next = ST_P_SWAP;
            ST_P_SWAP: state_next = ST_P_KS;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory requests and result push
    always_comb
    begin
        perm_req.we    = 1'b0;
        perm_req.waddr = n_reg;
        perm_req.wdata = n_reg;
        perm_req.raddr = i_reg + BYTE_W'(1);
        key_raddr      = '0;
        push.valid     = 1'b0;
        push.data      = data_reg ^ ks;
        unique case (state_reg)
            ST_IDLE:
            begin
                perm_req.raddr = i_reg + BYTE_W'(1);
            end
            ST_FILL:
            begin
                perm_req.we    = 1'b1;
                perm_req.raddr = '0;
            end
            ST_KS_J:
            begin
                perm_req.raddr = acc_new;
            end
            ST_KS_W1:
            begin
                perm_req.we    = 1'b1;
                perm_req.wdata = perm_rdata;
            end
            ST_KS_W2:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = acc_reg;
                perm_req.wdata = si_reg;
                perm_req.raddr = n_last ? BYTE_W'(1) : n_reg + BYTE_W'(1);
                key_raddr      = kpos_inc[KW-1:0];
            end
            ST_P_J:
            begin
                perm_req.raddr = j_new;
            end
            ST_P_SWAP:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rdata;
                perm_req.raddr = si_reg + perm_rdata;
            end
            ST_P_KS:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = si_reg;
                push.valid     = 1'b1;
            end
            default:
            begin
                perm_req.we = 1'b0;
            end
        endcase
    end

    // Key store write from key-load words in range
    assign key_we    = accept && (req_type == REQ_KEY)
                    && ({1'b0, key_index} < LEN_W'(KEY_DEPTH));
    assign key_waddr = key_index[KW-1:0];
    assign key_wdata = byte_in;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            sched_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE, ST_P_KS:
                begin
                    if (state_reg == ST_P_KS)
                    begin
                        sched_reg <= last_reg;
                    end
                    if (take_data && !sched_now)
                    begin
                        i_reg <= i_reg + BYTE_W'(1);
                    end
                end
                ST_KS_W2:
                begin
                    if (n_last)
                    begin
                        i_reg     <= BYTE_W'(1);
                        j_reg     <= '0;
                        sched_reg <= 1'b0;
                    end
                end
                ST_P_J:
                begin
                    j_reg <= j_new;
                end
                default:
                begin
                    sched_reg <= sched_reg;
                end
            endcase
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE, ST_P_KS:
            begin
                if (take_data)
                begin
                    data_reg <= byte_in;
                    last_reg <= last_of_buffer;
                    n_reg    <= '0;
                    len_reg  <= eff_len;
                end
            end
            ST_FILL:
            begin
                n_reg    <= n_reg + BYTE_W'(1);
                kpos_reg <= '0;
                acc_reg  <= '0;
            end
            ST_KS_J:
            begin
                si_reg  <= perm_rdata;
                acc_reg <= acc_new;
            end
            ST_KS_W2:
            begin
                n_reg    <= n_reg + BYTE_W'(1);
                kpos_reg <= kpos_inc;
            end
            ST_P_J:
            begin
                si_reg <= perm_rdata;
            end
            ST_P_SWAP:
            begin
                hit_reg <= ((si_reg + perm_rdata) == j_reg);
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    // A result is never pushed into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (q_level != 2'd2))
        else $error("result pushed into full queue");

    // Words wait while the schedule or a step is in progress
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && (state_reg != ST_P_KS)) |-> in_stall)
        else $error("word taken while busy");

    // The schedule ends with j cleared, i set to one and the first step under way
    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_KS_W2) && n_last) |=>
            ((state_reg == ST_P_J) && (i_reg == BYTE_W'(1)) && (j_reg == '0) && !sched_reg))
        else $error("schedule did not hand over cleanly");

endmodule

// File: sv/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// Top level of the RC4 byte cipher: key length register, memories, engine and output queue.
//
//   channel  | handshake            | word
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | req_type, key_index, byte_in, last_of_buffer
//   out      | out_valid / out_stall| byte_out
//   cfg      | cfg_valid / cfg_ready| key_length
//
// A key load is written into the key store as it is taken. A data byte runs its steps
// (permutation read, swap writes, keystream read) in turn over the single read and write
// port of the permutation memory. The first data byte after reset or after a last mark
// first runs the key schedule, a fill of the permutation memory and then the mixing steps.
// Reset clears the indices and arms the key schedule; memories are not cleared.
// Output stalls are absorbed by a two-entry queue; input stalls while the engine is busy,
// while the queue holds two words, or any word during the keystream read step.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [7:0]                  key_index,
    input  logic [rc4_pkg::BYTE_W-1:0]  byte_in,
    input  logic                        last_of_buffer,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]  byte_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rc4_pkg::LEN_W-1:0]   key_length
);
    import rc4_pkg::*;

    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    logic [LEN_W-1:0]  key_length_reg;
    perm_req_t         perm_req;
    logic [BYTE_W-1:0] perm_rdata;
    logic              key_we;
    logic [KW-1:0]     key_waddr;
    logic [BYTE_W-1:0] key_wdata;
    logic [KW-1:0]     key_raddr;
    logic [BYTE_W-1:0] key_rdata;
    logic [1:0]        q_level;
    push_t             push;

    // Hold the key length register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_length_reg <= key_length;
        end
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_req.we),
        .waddr (perm_req.waddr),
        .wdata (perm_req.wdata),
        .raddr (perm_req.raddr),
        .rdata (perm_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    rc4_engine #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .key_index      (key_index),
        .byte_in        (byte_in),
        .last_of_buffer (last_of_buffer),
        .key_length     (key_length_reg),
        .perm_req       (perm_req),
        .perm_rdata     (perm_rdata),
        .key_we         (key_we),
        .key_waddr      (key_waddr),
        .key_wdata      (key_wdata),
        .key_raddr      (key_raddr),
        .key_rdata      (key_rdata),
        .q_level        (q_level),
        .push           (push)
    );

    rc4_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_out  (byte_out),
        .level     (q_level)
    );

endmodule
